// ===== src/improv_serial_packet_parser_top_macros.svh =====
// Assertion macros for the Improv serial packet parser.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef IMPROV_SERIAL_PACKET_PARSER_TOP_MACROS_SVH
`define IMPROV_SERIAL_PACKET_PARSER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define ISP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ISP_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) pre |=> post) else $error(msg);
`else
`define ISP_ASSERT(lbl, prop, msg)
`define ISP_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/isp_pkg.sv =====
// Package for the Improv serial packet parser: item types, codes and constants.
// No dependencies.
package isp_pkg;

  localparam int unsigned POS_W         = 9;
  localparam int unsigned PAYLOAD_DEPTH = 128;
  localparam int unsigned RES_MAX       = 3;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd25;
  localparam logic [7:0]  START_BYTE    = 8'h49;
  localparam logic [7:0]  PROTO_VERSION = 8'h01;
  localparam logic [7:0]  TYPE_RPC      = 8'h03;
  localparam logic [POS_W-1:0] LEN_POS  = 9'd8;
  localparam logic [POS_W-1:0] CMD_POS  = 9'd9;
  localparam logic [POS_W-1:0] DATA_POS = 9'd10;

  localparam logic [7:0] CMD_WIFI  = 8'h01;
  localparam logic [7:0] CMD_STATE = 8'h02;
  localparam logic [7:0] CMD_INFO  = 8'h03;

  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_INVALID     = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN_CMD = 3'd2;

  localparam logic [2:0] ST_AUTHORIZED   = 3'd2;
  localparam logic [2:0] ST_PROVISIONING = 3'd3;
  localparam logic [2:0] ST_PROVISIONED  = 3'd4;

  typedef enum logic [2:0] {
    EV_DATA    = 3'd0,
    EV_ABORT   = 3'd1,
    EV_TIMEOUT = 3'd2,
    EV_STATE   = 3'd3,
    EV_RPC     = 3'd4,
    EV_INFO    = 3'd5,
    EV_WIFI    = 3'd6
  } isp_event_e;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
    logic       provisioning;
    logic       network_online;
  } isp_in_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] state_code;
    logic       is_error;
    logic [6:0] data_index;
    logic [7:0] data_value;
    logic [7:0] command;
    logic       session_active;
    logic       last;
  } isp_out_t;

  typedef struct packed {
    logic [1:0]               count;
    isp_out_t [RES_MAX-1:0]   res;
  } isp_group_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0: b = 8'h49;
      3'd1: b = 8'h4D;
      3'd2: b = 8'h50;
      3'd3: b = 8'h52;
      3'd4: b = 8'h4F;
      3'd5: b = 8'h56;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/isp_parser.sv =====
// Parse step of the Improv serial packet parser: packet state and result group.
// Depends on isp_pkg.
module isp_parser import isp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  isp_in_t    item_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  output isp_group_t group_o
);

  logic [7:0]       timeout_ticks_q;
  logic             in_packet_q, in_packet_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] end_q, end_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [7:0]       ticks_q, ticks_d;
  logic [2:0]       pend_q, pend_d;
  logic             active_q, active_d;

  isp_out_t [RES_MAX-1:0] res;
  logic [1:0]             n;
  logic [POS_W-1:0]       idx;
  logic [7:0]             b;
  logic                   advance;
  logic [2:0]             st;

  function automatic isp_out_t mk(input logic [2:0] ev, input logic [2:0] code,
                                  input logic err, input logic [6:0] di,
                                  input logic [7:0] dv);
    isp_out_t r;
    r = '0;
    r.event_res  = ev;
    r.state_code = code;
    r.is_error   = err;
    r.data_index = di;
    r.data_value = dv;
    return r;
  endfunction

  always_comb begin
    in_packet_d = in_packet_q;
    pos_d       = pos_q;
    end_d       = end_q;
    sum_d       = sum_q;
    cmd_d       = cmd_q;
    ticks_d     = ticks_q;
    pend_d      = pend_q;
    active_d    = active_q;
    res         = '0;
    n           = 2'd0;
    advance     = 1'b0;
    b           = item_i.byte_value;
    idx         = pos_q - DATA_POS;
    st          = ST_AUTHORIZED;
    if (item_i.provisioning) begin
      st = ST_PROVISIONING;
    end
    if (item_i.network_online) begin
      st = ST_PROVISIONED;
    end

    if (fire_i) begin
      if (item_i.action) begin
        if (in_packet_q) begin
          ticks_d = ticks_q - 8'd1;
          if (ticks_d == 8'd0) begin
            in_packet_d = 1'b0;
            res[n] = mk(EV_TIMEOUT, ERR_NONE, 1'b0, 7'd0, 8'd0);
            n = n + 2'd1;
          end
        end
      end else if (!in_packet_q) begin
        if (b == START_BYTE) begin
          in_packet_d = 1'b1;
          pos_d       = 9'd1;
          end_d       = CMD_POS;
          sum_d       = START_BYTE;
          cmd_d       = 8'h00;
          ticks_d     = timeout_ticks_q;
        end
      end else if (pos_q == 9'd6) begin
        if (b != PROTO_VERSION) begin
          in_packet_d = 1'b0;
          res[n] = mk(EV_ABORT, ERR_NONE, 1'b0, 7'd0, 8'd0);
          n = n + 2'd1;
        end else begin
          advance = 1'b1;
        end
      end else if (pos_q == 9'd7) begin
        if (b != TYPE_RPC) begin
          in_packet_d = 1'b0;
          res[n] = mk(EV_ABORT, ERR_NONE, 1'b0, 7'd0, 8'd0);
          n = n + 2'd1;
        end else begin
          active_d = 1'b1;
          advance  = 1'b1;
        end
      end else if (pos_q == LEN_POS) begin
        end_d   = CMD_POS + {1'b0, b};
        advance = 1'b1;
      end else if (pos_q == CMD_POS) begin
        cmd_d   = b;
        advance = 1'b1;
      end else if (pos_q >= end_q) begin
        in_packet_d = 1'b0;
        if (sum_q != b) begin
          pend_d = ERR_INVALID;
          res[n] = mk(EV_STATE, ERR_INVALID, 1'b1, 7'd0, 8'd0);
          n = n + 2'd1;
        end else begin
          case (cmd_q)
            CMD_WIFI: begin
              res[n] = mk(EV_WIFI, ERR_NONE, 1'b0, 7'd0, 8'd0);
              n = n + 2'd1;
            end
            CMD_STATE: begin
              if (pend_q == ERR_INVALID || pend_q == ERR_UNKNOWN_CMD) begin
                pend_d = ERR_NONE;
                res[n] = mk(EV_STATE, ERR_NONE, 1'b1, 7'd0, 8'd0);
                n = n + 2'd1;
              end
              res[n] = mk(EV_STATE, st, 1'b0, 7'd0, 8'd0);
              n = n + 2'd1;
              if (st == ST_PROVISIONED) begin
                res[n] = mk(EV_RPC, ERR_NONE, 1'b0, 7'd0, 8'd0);
                n = n + 2'd1;
                active_d = 1'b1;
              end
            end
            CMD_INFO: begin
              if (pend_q == ERR_INVALID || pend_q == ERR_UNKNOWN_CMD) begin
                pend_d = ERR_NONE;
                res[n] = mk(EV_STATE, ERR_NONE, 1'b1, 7'd0, 8'd0);
                n = n + 2'd1;
              end
              res[n] = mk(EV_INFO, ERR_NONE, 1'b0, 7'd0, 8'd0);
              n = n + 2'd1;
            end
            default: begin
              pend_d = ERR_UNKNOWN_CMD;
              res[n] = mk(EV_STATE, ERR_UNKNOWN_CMD, 1'b1, 7'd0, 8'd0);
              n = n + 2'd1;
            end
          endcase
        end
      end else if (pos_q < 9'd6) begin
        if (b != hdr_byte(pos_q[2:0])) begin
          in_packet_d = 1'b0;
          res[n] = mk(EV_ABORT, ERR_NONE, 1'b0, 7'd0, 8'd0);
          n = n + 2'd1;
        end else begin
          advance = 1'b1;
        end
      end else if (idx >= POS_W'(PAYLOAD_DEPTH)) begin
        in_packet_d = 1'b0;
        pend_d      = ERR_INVALID;
        res[n] = mk(EV_STATE, ERR_INVALID, 1'b1, 7'd0, 8'd0);
        n = n + 2'd1;
      end else begin
        res[n] = mk(EV_DATA, ERR_NONE, 1'b0, idx[6:0], b);
        n = n + 2'd1;
        advance = 1'b1;
      end

      if (advance) begin
        sum_d = sum_q + b;
        pos_d = pos_q + 9'd1;
      end
    end

    for (int i = 0; i < RES_MAX; i++) begin
      res[i].command        = cmd_d;
      res[i].session_active = active_d;
      res[i].last           = (2'(i) == n - 2'd1);
    end
    group_o.count = n;
    group_o.res   = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= TIMEOUT_RESET;
      in_packet_q     <= 1'b0;
      pos_q           <= '0;
      end_q           <= CMD_POS;
      sum_q           <= 8'h00;
      cmd_q           <= 8'h00;
      ticks_q         <= TIMEOUT_RESET;
      pend_q          <= ERR_NONE;
      active_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_ticks_q <= cfg_wdata_i;
      end
      in_packet_q <= in_packet_d;
      pos_q       <= pos_d;
      end_q       <= end_d;
      sum_q       <= sum_d;
      cmd_q       <= cmd_d;
      ticks_q     <= ticks_d;
      pend_q      <= pend_d;
      active_q    <= active_d;
    end
  end

endmodule

// ===== src/isp_result_queue.sv =====
// Result holding register of the Improv serial packet parser: up to three items.
// Depends on isp_pkg.
module isp_result_queue import isp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  isp_group_t group_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output isp_out_t   out_data_o
);

  isp_out_t [RES_MAX-1:0] res_q;
  logic [1:0]             cnt_q;
  logic                   pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = res_q[0];
  assign pop         = out_valid_o & out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= group_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= group_i.res;
    end else if (pop) begin
      res_q[0] <= res_q[1];
      res_q[1] <= res_q[2];
    end
  end

endmodule

// ===== src/improv_serial_packet_parser_top.sv =====
// Top level of the Improv serial packet parser.
// Depends on isp_pkg, isp_parser, isp_result_queue and the assertion macros header.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one item is one console byte
// or one idle tick, with the provisioning and network status of the device.
// Output channel (out_valid_o/out_ready_i/out_data_o): one item is one result;
// an input item causes zero to three results, and the last one carries last.
// Configuration: cfg_we_i writes cfg_wdata_i into the timeout tick budget.
// The results of an item are presented the cycle after it is accepted and
// leave one per cycle while out_ready_i is high. With out_ready_i high, an item
// with at most one result sustains one item per cycle; one with more results
// holds the register, and the next is taken in the cycle its last one leaves.
// The rate is set by the three-entry result register, which the parse step
// refills only when it is empty or draining its final entry.
// When the receiver stalls, the held results stay and in_ready_o drops until
// the final one can leave. Reset clears the packet state, the pending error
// and the session flag, empties the result register and sets the budget to 25.
`include "improv_serial_packet_parser_top_macros.svh"
module improv_serial_packet_parser_top import isp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  isp_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output isp_out_t   out_data_o,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i
);

  logic       in_fire;
  isp_group_t group;

  assign in_fire = in_valid_i & in_ready_o;

  isp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (in_fire),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .group_o     (group)
  );

  isp_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire),
    .group_i     (group),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `ISP_ASSERT(a_ready_when_stalled, (in_ready_o && !out_ready_i) |-> !out_valid_o, "input ready while results are stalled")
  `ISP_ASSERT_NEXT(a_group_continues, (out_valid_o && !out_data_o.last), out_valid_o, "result group ended without its last item")
  `ISP_ASSERT(a_data_alone, (out_valid_o && out_data_o.event_res == EV_DATA) |-> out_data_o.last, "data byte item not alone")
  `ISP_ASSERT(a_rpc_session, (out_valid_o && out_data_o.event_res == EV_RPC) |-> out_data_o.session_active, "rpc response without session")

endmodule

// ===== verif/tb.sv =====
// Testbench for the Improv serial packet parser top level.
// Depends on isp_pkg and improv_serial_packet_parser_top; it drives byte and tick items,
// predicts every result item in step with the block and checks them in order.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import isp_pkg::*;

  localparam logic [8:0]  VER_POS    = 9'd6;
  localparam logic [8:0]  TYPE_POS   = 9'd7;
  localparam logic [47:0] MAGIC      = "IMPROV";
  localparam int          WDOG_LIMIT = 3000;
  localparam int          IN_W       = $bits(isp_in_t);

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  isp_in_t    in_data_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  isp_out_t   out_data_o;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = '0;

  improv_serial_packet_parser_top i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o,
    .cfg_we_i,
    .cfg_wdata_i
  );

  always #2 clk_i = ~clk_i;

  logic       pk_open   = 1'b0;
  logic [8:0] pk_pos    = '0;
  logic [8:0] pk_end    = CMD_POS;
  logic [7:0] pk_sum    = '0;
  logic [7:0] pk_cmd    = '0;
  logic [7:0] pk_ticks  = TIMEOUT_RESET;
  logic [2:0] pend_err  = ERR_NONE;
  logic       sess_flag = 1'b0;
  logic [7:0] tmo_budget = TIMEOUT_RESET;

  isp_out_t expected_results[$];
  isp_out_t item_results[$];
  int n_err       = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  int rdy_run     = 0;
  int rdy_mode    = 0;

  function automatic logic [7:0] hdr_at(input int k);
    if (k < 6) return MAGIC[8*(5-k) +: 8];
    if (k == 6) return PROTO_VERSION;
    return TYPE_RPC;
  endfunction

  function automatic void add_res(input isp_event_e ev, input logic [2:0] code,
                                  input logic err, input logic [6:0] idx,
                                  input logic [7:0] val);
    isp_out_t r;
    r            = '0;
    r.event_res  = ev;
    r.state_code = code;
    r.is_error   = err;
    r.data_index = idx;
    r.data_value = val;
    r.command    = pk_cmd;
    item_results.push_back(r);
  endfunction

  function automatic void drop_packet();
    pk_open = 1'b0;
    add_res(EV_ABORT, ERR_NONE, 1'b0, '0, '0);
  endfunction

  function automatic void flush_pending();
    if (pend_err == ERR_INVALID || pend_err == ERR_UNKNOWN_CMD) begin
      pend_err = ERR_NONE;
      add_res(EV_STATE, ERR_NONE, 1'b1, '0, '0);
    end
  endfunction

  function automatic void close_packet(input logic [7:0] b, input logic prov,
                                       input logic online);
    logic [2:0] st;
    pk_open = 1'b0;
    if (pk_sum != b) begin
      pend_err = ERR_INVALID;
      add_res(EV_STATE, ERR_INVALID, 1'b1, '0, '0);
      return;
    end
    case (pk_cmd)
      CMD_WIFI: begin
        add_res(EV_WIFI, ERR_NONE, 1'b0, '0, '0);
      end
      CMD_STATE: begin
        st = ST_AUTHORIZED;
        if (prov) st = ST_PROVISIONING;
        if (online) st = ST_PROVISIONED;
        flush_pending();
        add_res(EV_STATE, st, 1'b0, '0, '0);
        if (st == ST_PROVISIONED) begin
          add_res(EV_RPC, ERR_NONE, 1'b0, '0, '0);
          sess_flag = 1'b1;
        end
      end
      CMD_INFO: begin
        flush_pending();
        add_res(EV_INFO, ERR_NONE, 1'b0, '0, '0);
      end
      default: begin
        pend_err = ERR_UNKNOWN_CMD;
        add_res(EV_STATE, ERR_UNKNOWN_CMD, 1'b1, '0, '0);
      end
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic prov,
                                     input logic online);
    logic [8:0] p;
    logic [8:0] idx;
    p = pk_pos;
    if (p == VER_POS || p == TYPE_POS) begin
      if (b != hdr_at(int'(p))) begin
        drop_packet();
        return;
      end
      if (p == TYPE_POS) sess_flag = 1'b1;
    end else if (p == LEN_POS) begin
      pk_end = CMD_POS + 9'(b);
    end else if (p == CMD_POS) begin
      pk_cmd = b;
    end else if (p >= pk_end) begin
      close_packet(b, prov, online);
      return;
    end else if (p < VER_POS) begin
      if (b != hdr_at(int'(p))) begin
        drop_packet();
        return;
      end
    end else begin
      idx = p - DATA_POS;
      if (idx >= PAYLOAD_DEPTH) begin
        pk_open  = 1'b0;
        pend_err = ERR_INVALID;
        add_res(EV_STATE, ERR_INVALID, 1'b1, '0, '0);
        return;
      end
      add_res(EV_DATA, ERR_NONE, 1'b0, idx[6:0], b);
    end
    pk_sum = pk_sum + b;
    pk_pos = p + 9'd1;
  endfunction

  function automatic void predict_results(input isp_in_t it);
    item_results.delete();
    if (it.action) begin
      if (pk_open) begin
        pk_ticks = pk_ticks - 8'd1;
        if (pk_ticks == 0) begin
          pk_open = 1'b0;
          add_res(EV_TIMEOUT, ERR_NONE, 1'b0, '0, '0);
        end
      end
    end else if (pk_open) begin
      parse_byte(it.byte_value, it.provisioning, it.network_online);
    end else if (it.byte_value == START_BYTE) begin
      pk_open  = 1'b1;
      pk_pos   = '0;
      pk_end   = CMD_POS;
      pk_sum   = '0;
      pk_cmd   = '0;
      pk_ticks = tmo_budget;
      parse_byte(it.byte_value, it.provisioning, it.network_online);
    end
    foreach (item_results[i]) begin
      item_results[i].session_active = sess_flag;
      item_results[i].last           = (i == item_results.size() - 1);
      expected_results.push_back(item_results[i]);
    end
  endfunction

  task automatic send_item(input isp_in_t it);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_results(it);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic prov, input logic online);
    isp_in_t it;
    it.action         = 1'b0;
    it.byte_value     = b;
    it.provisioning   = prov;
    it.network_online = online;
    send_item(it);
  endtask

  task automatic send_tick();
    isp_in_t it;
    it        = isp_in_t'(IN_W'($urandom));
    it.action = 1'b1;
    send_item(it);
  endtask

  task automatic send_packet(input logic [7:0] len, input logic [7:0] cmd, input bit bad_sum,
                             input logic prov, input logic online, input int data_cap,
                             input int tick_pct);
    logic [7:0] sum;
    logic [7:0] b;
    int n_data;
    sum    = '0;
    n_data = (len > 1) ? int'(len) - 1 : 0;
    if (n_data > data_cap) n_data = data_cap;
    for (int i = 0; i < 10 + n_data; i++) begin
      if (i < 8) b = hdr_at(i);
      else if (i == 8) b = len;
      else if (i == 9) b = cmd;
      else b = 8'($urandom);
      if (i > 0 && $urandom_range(0, 99) < tick_pct) send_tick();
      send_byte(b, 1'($urandom), 1'($urandom));
      sum = sum + b;
    end
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum, prov, online);
  endtask

  task automatic send_broken(input int k);
    for (int i = 0; i < k; i++) send_byte(hdr_at(i), 1'($urandom), 1'($urandom));
    send_byte(hdr_at(k) ^ 8'($urandom_range(1, 255)), 1'($urandom), 1'($urandom));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_budget(input logic [7:0] v);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    tmo_budget = v;
  endtask

  task automatic test_idle_noise();
    send_tick();
    send_byte(8'h4D, 1'b0, 1'b1);
    send_tick();
  endtask

  task automatic test_header_aborts();
    send_broken(1);
    send_broken(6);
    send_broken(7);
  endtask

  task automatic test_timeout();
    write_budget(8'd2);
    send_byte(START_BYTE, 1'b1, 1'b0);
    send_tick();
    send_byte(8'h4D, 1'b0, 1'b1);
    send_tick();
    send_byte(8'h50, 1'b1, 1'b1);
  endtask

  task automatic test_commands();
    write_budget(8'd25);
    send_packet(8'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 255, 0);
    send_packet(8'd0, CMD_INFO, 1'b0, 1'b0, 1'b0, 255, 0);
    send_packet(8'd0, CMD_WIFI, 1'b1, 1'b1, 1'b0, 255, 0);
    send_packet(8'd0, CMD_STATE, 1'b0, 1'b0, 1'b0, 255, 0);
    send_packet(8'd0, CMD_WIFI, 1'b0, 1'b0, 1'b1, 255, 0);
    send_packet(8'd0, CMD_STATE, 1'b0, 1'b1, 1'b0, 255, 0);
  endtask

  task automatic test_overflow();
    send_packet(8'd255, CMD_INFO, 1'b0, 1'b0, 1'b0, 129, 0);
    send_packet(8'd0, CMD_STATE, 1'b0, 1'b1, 1'b1, 255, 0);
  endtask

  always @(negedge clk_i) begin
    if (rdy_run == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_run  = $urandom_range(4, 16);
    end
    rdy_run--;
    case (rdy_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (rdy_run == 0);
    endcase
  end

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      n_err++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    isp_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $error("result item with nothing expected: %h", out_data_o);
        n_err++;
      end else begin
        want = expected_results.pop_front();
        check_field("event_res", 8'(want.event_res), 8'(out_data_o.event_res));
        check_field("state_code", 8'(want.state_code), 8'(out_data_o.state_code));
        check_field("is_error", 8'(want.is_error), 8'(out_data_o.is_error));
        check_field("data_index", 8'(want.data_index), 8'(out_data_o.data_index));
        check_field("data_value", want.data_value, out_data_o.data_value);
        check_field("command", want.command, out_data_o.command);
        check_field("session_active", 8'(want.session_active),
                    8'(out_data_o.session_active));
        check_field("last", 8'(want.last), 8'(out_data_o.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_idle_noise();
    test_header_aborts();
    test_timeout();
    test_commands();
    test_overflow();
    drain_results();
    repeat (10) @(posedge clk_i);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
